>>> rtl/core/tmo_pkg.sv
// Shared types and constants for the timeout table core.
`default_nettype none

package tmo_pkg;

   // Width of a remaining-tick count.
   localparam int unsigned REM_W = 32;

   // Width of the action id on the ports.
   localparam int unsigned PORT_ID_W = 8;

   // Request kinds.
   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_ADD  = 1'b1;

   // Result kinds.
   localparam logic KIND_ADD   = 1'b0;
   localparam logic KIND_FIRED = 1'b1;

   // One request word.
   typedef struct packed {
      logic                 req_type;
      logic [PORT_ID_W-1:0] action_id;
      logic [REM_W-1:0]     duration;
   } req_word_type;

   // One result word.
   typedef struct packed {
      logic                 result_kind;
      logic                 accepted;
      logic [PORT_ID_W-1:0] fired_id;
      logic                 last;
   } rsp_word_type;

   // Flags from the shared compare and decrement unit.
   typedef struct packed {
      logic id_match;
      logic rem_zero;
      logic dec_zero;
   } unit_stat_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_RD,
      ST_ADD_CMP,
      ST_TICK_RD,
      ST_TICK_EVAL,
      ST_MOVE_RD,
      ST_MOVE_WR
   } state_type;

endpackage

`default_nettype wire

>>> rtl/core/ms_timeout_table_core.sv
// Top level of the timeout table: sequencer, entry store and shared unit.
// An add restarts the slot holding the id, else appends one if there is room.
// A tick visits each live slot; the last live entry moves into each removed one.
// Every slot visit runs through the one read port and the one decrement unit.
// Results are one-cycle strobes on rsp_valid; the receiver cannot stall them.
// Synchronous reset empties the table; slot contents stay unknown until written.
`default_nettype none

module ms_timeout_table_core #(
   parameter int unsigned SLOTS   = 4,
   parameter int unsigned ID_BITS = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output      logic                  busy,
   input  wire tmo_pkg::req_word_type req_word,
   output      logic                  rsp_valid,
   output      tmo_pkg::rsp_word_type rsp_word
);
   import tmo_pkg::*;

   localparam int unsigned IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int unsigned CNT_W    = $clog2(SLOTS + 1);
   localparam int unsigned ID_EXT_W = ID_BITS + PORT_ID_W;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   cnt_dec;
   logic [ID_BITS-1:0] key_id_ff, key_id_in;
   logic [REM_W-1:0]   dur_ff, dur_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [ID_BITS-1:0] pend_id_ff, pend_id_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_word_ff, rsp_word_in;

   logic               accept;
   logic [ID_EXT_W-1:0] req_id_ext;
   logic [ID_BITS-1:0] req_id;
   logic [ID_EXT_W-1:0] key_id_ext;
   logic [ID_EXT_W-1:0] pend_id_ext;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [ID_BITS-1:0] wr_id;
   logic [REM_W-1:0]   wr_rem;
   logic [IDX_W-1:0]   rd_addr;
   logic [ID_BITS-1:0] rd_id;
   logic [REM_W-1:0]   rd_rem;
   unit_stat_type      ustat;
   logic [REM_W-1:0]   rem_dec;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // Fit ids between the port width and the stored width.
   assign req_id_ext  = {{ID_BITS{1'b0}}, req_word.action_id};
   assign req_id      = req_id_ext[ID_BITS-1:0];
   assign key_id_ext  = {{PORT_ID_W{1'b0}}, key_id_ff};
   assign pend_id_ext = {{PORT_ID_W{1'b0}}, pend_id_ff};
   assign cnt_dec     = count_ff - {{(CNT_W-1){1'b0}}, 1'b1};

   tmo_store #(
      .SLOTS   (SLOTS),
      .ID_BITS (ID_BITS),
      .IDX_W   (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_id   (wr_id),
      .wr_rem  (wr_rem),
      .rd_addr (rd_addr),
      .rd_id   (rd_id),
      .rd_rem  (rd_rem)
   );

   tmo_unit #(
      .ID_BITS (ID_BITS)
   ) u_unit (
      .rd_id   (rd_id),
      .rd_rem  (rd_rem),
      .key_id  (key_id_ff),
      .stat    (ustat),
      .rem_dec (rem_dec)
   );

   // Next-state logic of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_word.req_type == REQ_ADD) ? ST_ADD_RD : ST_TICK_RD;
            end
         end
         ST_ADD_RD:    state_in = (idx_ff == count_ff) ? ST_IDLE : ST_ADD_CMP;
         ST_ADD_CMP:   state_in = ustat.id_match ? ST_IDLE : ST_ADD_RD;
         ST_TICK_RD:   state_in = (idx_ff == count_ff) ? ST_IDLE : ST_TICK_EVAL;
         ST_TICK_EVAL: begin
            state_in = (ustat.rem_zero || ustat.dec_zero) ? ST_MOVE_RD : ST_TICK_RD;
         end
         ST_MOVE_RD:   state_in = ST_MOVE_WR;
         ST_MOVE_WR:   state_in = ST_TICK_RD;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Datapath control: store access, counters, pending fired word and results.
   always_comb begin
      idx_in        = idx_ff;
      count_in      = count_ff;
      key_id_in     = key_id_ff;
      dur_in        = dur_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      rsp_valid_in  = 1'b0;
      rsp_word_in   = '0;
      wr_en         = 1'b0;
      wr_addr       = idx_ff[IDX_W-1:0];
      wr_id         = key_id_ff;
      wr_rem        = dur_ff;
      rd_addr       = idx_ff[IDX_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               key_id_in     = req_id;
               dur_in        = req_word.duration;
               idx_in        = '0;
               pend_valid_in = 1'b0;
            end
         end
         ST_ADD_RD: begin
            // Searched every live slot without a hit: append if there is room.
            if (idx_ff == count_ff) begin
               rsp_valid_in         = 1'b1;
               rsp_word_in.result_kind = KIND_ADD;
               rsp_word_in.fired_id = key_id_ext[PORT_ID_W-1:0];
               rsp_word_in.last     = 1'b1;
               if (count_ff != CNT_W'(SLOTS)) begin
                  wr_en                = 1'b1;
                  count_in             = count_ff + {{(CNT_W-1){1'b0}}, 1'b1};
                  rsp_word_in.accepted = 1'b1;
               end
            end
         end
         ST_ADD_CMP: begin
            // A hit restarts that slot's count in place.
            if (ustat.id_match) begin
               wr_en                   = 1'b1;
               rsp_valid_in            = 1'b1;
               rsp_word_in.result_kind = KIND_ADD;
               rsp_word_in.accepted    = 1'b1;
               rsp_word_in.fired_id    = key_id_ext[PORT_ID_W-1:0];
               rsp_word_in.last        = 1'b1;
            end else begin
               idx_in = idx_ff + {{(CNT_W-1){1'b0}}, 1'b1};
            end
         end
         ST_TICK_RD: begin
            // End of the scan: the held fired word goes out as the last one.
            if (idx_ff == count_ff && pend_valid_ff) begin
               rsp_valid_in            = 1'b1;
               rsp_word_in.result_kind = KIND_FIRED;
               rsp_word_in.fired_id    = pend_id_ext[PORT_ID_W-1:0];
               rsp_word_in.last        = 1'b1;
               pend_valid_in           = 1'b0;
            end
         end
         ST_TICK_EVAL: begin
            if (!ustat.rem_zero) begin
               wr_en  = 1'b1;
               wr_id  = rd_id;
               wr_rem = rem_dec;
               if (ustat.dec_zero) begin
                  // Hold the new fired word; release the older one as not last.
                  if (pend_valid_ff) begin
                     rsp_valid_in            = 1'b1;
                     rsp_word_in.result_kind = KIND_FIRED;
                     rsp_word_in.fired_id    = pend_id_ext[PORT_ID_W-1:0];
                  end
                  pend_valid_in = 1'b1;
                  pend_id_in    = rd_id;
               end else begin
                  idx_in = idx_ff + {{(CNT_W-1){1'b0}}, 1'b1};
               end
            end
         end
         ST_MOVE_RD: begin
            rd_addr = cnt_dec[IDX_W-1:0];
         end
         ST_MOVE_WR: begin
            // The last live entry takes over the removed slot.
            wr_en    = 1'b1;
            wr_id    = rd_id;
            wr_rem   = rd_rem;
            count_in = cnt_dec;
         end
         default: begin
            idx_in = idx_ff;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      key_id_ff   <= key_id_in;
      dur_ff      <= dur_in;
      pend_id_ff  <= pend_id_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef ASSERT_OFF
   // The table never holds more live entries than it has slots.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(SLOTS))
      else $error("live entry count above slot count");

   // The scan index never passes the live entry count.
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      busy |-> idx_ff <= count_ff)
      else $error("scan index beyond live entries");

   // A fired word that is not the last leaves the block still busy.
   a_not_last_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.last |-> busy)
      else $error("non-final word while idle");

   // An add answer is a single final word and ends the request.
   a_add_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.result_kind == KIND_ADD |-> rsp_word.last && !busy)
      else $error("add answer not final");

   // A fired word never claims acceptance.
   a_fired_acc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.result_kind == KIND_FIRED |-> !rsp_word.accepted)
      else $error("fired word with accepted set");
`endif

endmodule

`default_nettype wire

>>> rtl/core/tmo_store.sv
// Entry store of the timeout table: one write port and one registered read port.
`default_nettype none

module tmo_store #(
   parameter int unsigned SLOTS   = 4,
   parameter int unsigned ID_BITS = 8,
   parameter int unsigned IDX_W   = 2
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [IDX_W-1:0]           wr_addr,
   input  wire logic [ID_BITS-1:0]         wr_id,
   input  wire logic [tmo_pkg::REM_W-1:0]  wr_rem,
   input  wire logic [IDX_W-1:0]           rd_addr,
   output      logic [ID_BITS-1:0]         rd_id,
   output      logic [tmo_pkg::REM_W-1:0]  rd_rem
);
   import tmo_pkg::*;

   logic [ID_BITS-1:0] id_mem  [SLOTS];
   logic [REM_W-1:0]   rem_mem [SLOTS];
   logic [ID_BITS-1:0] rd_id_ff;
   logic [REM_W-1:0]   rd_rem_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         id_mem[wr_addr]  <= wr_id;
         rem_mem[wr_addr] <= wr_rem;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_id_ff  <= id_mem[rd_addr];
      rd_rem_ff <= rem_mem[rd_addr];
   end

   assign rd_id  = rd_id_ff;
   assign rd_rem = rd_rem_ff;

endmodule

`default_nettype wire

>>> rtl/core/tmo_unit.sv
// Shared compare and decrement unit used for every slot visit.
`default_nettype none

module tmo_unit #(
   parameter int unsigned ID_BITS = 8
) (
   input  wire logic [ID_BITS-1:0]         rd_id,
   input  wire logic [tmo_pkg::REM_W-1:0]  rd_rem,
   input  wire logic [ID_BITS-1:0]         key_id,
   output      tmo_pkg::unit_stat_type     stat,
   output      logic [tmo_pkg::REM_W-1:0]  rem_dec
);
   import tmo_pkg::*;

   // Decrement the stored count and flag the interesting values.
   always_comb begin
      rem_dec       = rd_rem - {{(REM_W-1){1'b0}}, 1'b1};
      stat.id_match = (rd_id == key_id);
      stat.rem_zero = (rd_rem == '0);
      stat.dec_zero = (rem_dec == '0) && (rd_rem != '0);
   end

endmodule

`default_nettype wire

>>> dv/tb.sv
// Testbench for the timeout table core: directed and random requests checked against a predictor.
`timescale 1ns / 100ps

module tb;
   import tmo_pkg::*;

   localparam int unsigned SLOTS        = 4;
   localparam int unsigned ID_W         = 8;
   localparam int unsigned RANDOM_ITEMS = 280;

   logic         clock;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_word_type req_word = '0;
   logic         rsp_valid;
   rsp_word_type rsp_word;

   // Predicts the answers and fired timeouts, and checks them in order.
   class timeout_tracker;
      logic [REM_W-1:0] slot_left [SLOTS];
      logic [ID_W-1:0]  slot_id   [SLOTS];
      int unsigned      live;
      rsp_word_type     due_answers[$];
      int unsigned      mismatches;

      function new();
         live       = 0;
         mismatches = 0;
      endfunction

      // Apply one accepted word to the table copy and queue what it causes.
      function void apply_request(req_word_type w);
         int unsigned      i;
         logic [ID_W-1:0]  id;
         rsp_word_type     r;
         rsp_word_type     fires[$];
         if (w.req_type == REQ_ADD) begin
            id = w.action_id[ID_W-1:0];
            i  = 0;
            while (i < live && slot_id[i] != id) i++;
            r             = '0;
            r.result_kind = KIND_ADD;
            r.fired_id    = id;
            r.last        = 1'b1;
            if (i < SLOTS) begin
               slot_left[i] = w.duration;
               slot_id[i]   = id;
               if (i == live) live++;
               r.accepted = 1'b1;
            end
            due_answers.push_back(r);
         end else begin
            // Scan upward; a removed slot takes the last entry and is visited again.
            i = 0;
            while (i < live) begin
               if (slot_left[i] == '0) begin
                  slot_left[i] = slot_left[live-1];
                  slot_id[i]   = slot_id[live-1];
                  live--;
               end else begin
                  slot_left[i] = slot_left[i] - 1;
                  if (slot_left[i] == '0) begin
                     r             = '0;
                     r.result_kind = KIND_FIRED;
                     r.fired_id    = slot_id[i];
                     fires.push_back(r);
                  end else begin
                     i++;
                  end
               end
            end
            if (fires.size() > 0) fires[fires.size()-1].last = 1'b1;
            foreach (fires[j]) due_answers.push_back(fires[j]);
         end
      endfunction

      // Compare one result word with the oldest expectation, field by field.
      function void compare_answer(rsp_word_type got);
         rsp_word_type want;
         if (due_answers.size() == 0) begin
            $display("%0t: unexpected word kind=%0d accepted=%0d id=%0h last=%0d", $time,
                     got.result_kind, got.accepted, got.fired_id, got.last);
            mismatches++;
            return;
         end
         want = due_answers.pop_front();
         if (got.result_kind !== want.result_kind) begin
            $display("%0t: result_kind expected %0d actual %0d", $time,
                     want.result_kind, got.result_kind);
            mismatches++;
         end
         if (got.accepted !== want.accepted) begin
            $display("%0t: accepted expected %0d actual %0d", $time, want.accepted, got.accepted);
            mismatches++;
         end
         if (got.fired_id !== want.fired_id) begin
            $display("%0t: fired_id expected %0h actual %0h", $time, want.fired_id, got.fired_id);
            mismatches++;
         end
         if (got.last !== want.last) begin
            $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
            mismatches++;
         end
      endfunction

      function int unsigned pending();
         return due_answers.size();
      endfunction
   endclass

   timeout_tracker board;

   ms_timeout_table_core #(
      .SLOTS   (SLOTS),
      .ID_BITS (ID_W)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Every strobed result word is checked at the edge that ends its cycle.
   always @(posedge clock) begin
      if (reset == 1'b0 && rsp_valid === 1'b1) board.compare_answer(rsp_word);
   end

   function automatic req_word_type make_word(logic kind, logic [7:0] id, logic [31:0] dur);
      req_word_type w;
      w.req_type  = kind;
      w.action_id = id;
      w.duration  = dur;
      return w;
   endfunction

   // Present one word and hold it until the core takes it.
   task automatic send_word(req_word_type w);
      start    <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy !== 1'b0);
      board.apply_request(w);
   endtask

   // Hold off the sender until every expected word has come back.
   task automatic wait_for_drain();
      start <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   initial begin
      int unsigned k;
      int unsigned roll;
      logic [7:0]  pick_id;
      logic [31:0] pick_dur;
      logic [7:0]  id_pool [6];
      board = new();
      foreach (id_pool[j]) id_pool[j] = 8'($urandom_range(0, 255));
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty tick with ignored fields, fill, full reject, restart while full.
      send_word(make_word(REQ_TICK, 8'hFF, 32'hFFFF_FFFF));
      send_word(make_word(REQ_ADD, 8'h00, 32'd1));
      send_word(make_word(REQ_ADD, 8'hFF, 32'hFFFF_FFFF));
      send_word(make_word(REQ_ADD, 8'h5A, 32'd0));
      send_word(make_word(REQ_ADD, 8'hA5, 32'd2));
      send_word(make_word(REQ_ADD, 8'h33, 32'd3));
      send_word(make_word(REQ_ADD, 8'h5A, 32'd1));
      // Fires in slot 0, the moved entry is processed next, then a second fire.
      send_word(make_word(REQ_TICK, 8'h00, 32'd0));
      // A chain of fires and a silent removal of a zero-count entry.
      send_word(make_word(REQ_ADD, 8'h11, 32'd0));
      send_word(make_word(REQ_ADD, 8'h22, 32'd1));
      send_word(make_word(REQ_TICK, 8'h3C, 32'h1234_5678));
      // Four fires from one tick.
      send_word(make_word(REQ_ADD, 8'h01, 32'd1));
      send_word(make_word(REQ_ADD, 8'h02, 32'd1));
      send_word(make_word(REQ_ADD, 8'h04, 32'd1));
      send_word(make_word(REQ_ADD, 8'hFF, 32'd1));
      send_word(make_word(REQ_TICK, 8'h00, 32'd0));
      send_word(make_word(REQ_TICK, 8'h00, 32'd0));
      // Restart of a present id while the table has room.
      send_word(make_word(REQ_ADD, 8'h7E, 32'd5));
      send_word(make_word(REQ_ADD, 8'h7E, 32'd2));
      send_word(make_word(REQ_TICK, 8'h00, 32'd0));
      send_word(make_word(REQ_TICK, 8'h00, 32'd0));
      wait_for_drain();

      // Random: mostly small counts on a few recurring ids, so restarts and fills happen.
      for (k = 0; k < RANDOM_ITEMS; k++) begin
         roll = $urandom_range(0, 99);
         if (roll < 45) begin
            send_word(make_word(REQ_TICK, 8'($urandom), $urandom));
         end else begin
            roll     = $urandom_range(0, 99);
            pick_id  = (roll < 80) ? id_pool[$urandom_range(0, 5)] : 8'($urandom_range(0, 255));
            roll     = $urandom_range(0, 99);
            if (roll < 12) pick_dur = 32'd0;
            else if (roll < 75) pick_dur = 32'($urandom_range(1, 4));
            else if (roll < 92) pick_dur = 32'($urandom_range(5, 16));
            else pick_dur = $urandom;
            send_word(make_word(REQ_ADD, pick_id, pick_dur));
         end
         // Bursts of sender gaps in alternate stretches, none near the end.
         if (k == 90 || k == 190) begin
            wait_for_drain();
         end else if (k < RANDOM_ITEMS - 40 && ((k / 30) % 2) == 0 &&
                      $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
      end

      start <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (board.mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Guard against a hang.
   initial begin
      #(2_000_000);
      $display("simulation failed");
      $finish;
   end

endmodule
